@@ sv/replay_ring_time_search_defines.svh @@
// Assertion macros shared by the ring search checker.
`ifndef REPLAY_RING_TIME_SEARCH_DEFINES_SVH
`define REPLAY_RING_TIME_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define RRTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define RRTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rrts_pkg.sv @@
// Types, codes and helpers shared by the replay ring time search block.
`timescale 1ns / 1ps
package rrts_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  typedef logic [AW-1:0] slot_t;
  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_READ   = 3'd2,
    OP_AGE    = 3'd3,
    OP_KEY    = 3'd4,
    OP_NEXT   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_RANGE    = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LOOK,
    S_APPEND,
    S_AGE_RD,
    S_AGE_EV,
    S_KEY_RD,
    S_KEY_EV
  } state_e;

  typedef struct packed {
    logic [31:0] ref_v;
    logic [7:0]  stream;
    logic        is_key;
    logic [31:0] time_v;
  } entry_t;

  typedef struct packed {
    logic   rd_en;
    logic   wr_en;
    slot_t  addr;
    entry_t wdata;
  } mem_req_t;

  typedef struct packed {
    cnt_t        held;
    logic [31:0] ev_ref;
    logic        ev_valid;
    entry_t      entry;
    slot_t       pos;
    status_e     status;
  } result_t;

  // Physical slot of an age-ordered position; position 0 is the oldest entry.
  function automatic slot_t slot_of(slot_t wr_slot, cnt_t held, slot_t pos);
    slot_of = slot_t'(wr_slot - held[AW-1:0] + pos);
  endfunction

endpackage

@@ sv/rrts_mem.sv @@
// Descriptor storage: one port that either reads (registered) or writes per cycle.
`timescale 1ns / 1ps
module rrts_mem
  import rrts_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/replay_ring_time_search.sv @@
// Top level of the replay ring: descriptor store, sequencer and result register.
`timescale 1ns / 1ps
// The block holds up to 1024 packet descriptors in one single-port memory and
// handles one word at a time; it is ready again as soon as the result of the
// previous word is computed, even while that result still waits at the output.
// Every access to the ring goes through the one memory port, whose read data is
// registered, so each probe is a read followed by an evaluation. Clear and any
// operation answered without a lookup finish at decode; append reads the slot
// it overwrites and then writes it, and read and next read one entry. Find by
// age makes one probe per binary-search step, at most about 12 for a full ring.
// Find keyframe makes one probe per entry scanned from the start position. A
// stalled output holds the sequencer at its last step.
module replay_ring_time_search
  import rrts_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_time, entry_is_key, stream_id, payload_ref, position, current_time,
  // age_limit, invert_match, zero pad
  input  logic [151:0] s_axis_tdata,
  // opcode
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, result_position, out_time, out_is_key, out_stream, out_payload_ref,
  // evicted_valid, evicted_ref, held_count, zero pad
  output logic [135:0] m_axis_tdata
);

  state_e      state_q, state_d;
  op_e         op_q, op_d;
  logic [31:0] e_time_q, e_time_d;
  logic        e_key_q, e_key_d;
  logic [7:0]  stream_q, stream_d;
  logic [31:0] e_ref_q, e_ref_d;
  slot_t       pos_q, pos_d;
  logic [31:0] now_q, now_d;
  logic [31:0] limit_q, limit_d;
  logic        inv_q, inv_d;

  slot_t       wslot_q, wslot_d;
  cnt_t        count_q, count_d;
  cnt_t        lo_q, lo_d;
  cnt_t        hi_q, hi_d;
  cnt_t        idx_q, idx_d;
  logic        m_valid_q, m_valid_d;
  result_t     m_data_q, m_data_d;

  mem_req_t    mem_req;
  entry_t      rd_data;
  result_t     res;
  logic        load_out;

  logic        accept, out_free, empty, rng_bad, nxt_ok, full;
  cnt_t        pos_ext, nxt_pos, mid_c, idx_inc;
  logic [31:0] age_diff;
  logic        old_ok, age_done, key_same, key_hit, key_last;

  rrts_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rd_data)
  );

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign empty    = (count_q == '0);
  assign full     = (count_q == cnt_t'(DEPTH));
  assign pos_ext  = cnt_t'(pos_q);
  assign rng_bad  = (pos_ext >= count_q);
  assign nxt_pos  = pos_ext + cnt_t'(1);
  assign nxt_ok   = (nxt_pos < count_q);
  assign mid_c    = lo_q + ((hi_q - lo_q) >> 1);
  assign idx_inc  = idx_q + cnt_t'(1);
  assign key_last = (idx_inc >= count_q);
  assign age_diff = now_q - rd_data.time_v;
  assign old_ok   = !age_diff[31] && (age_diff >= limit_q);
  assign age_done = old_ok ? (lo_q == idx_q) : (hi_q == idx_q);
  assign key_same = (rd_data.stream == stream_q);
  assign key_hit  = rd_data.is_key && (inv_q ? !key_same : key_same);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (out_free) begin
          unique case (op_q)
            OP_APPEND: state_d = S_APPEND;
            OP_READ:   state_d = (empty || rng_bad) ? S_IDLE : S_LOOK;
            OP_AGE:    state_d = empty ? S_IDLE : S_AGE_RD;
            OP_KEY:    state_d = (empty || rng_bad) ? S_IDLE : S_KEY_RD;
            OP_NEXT:   state_d = (empty || !nxt_ok) ? S_IDLE : S_LOOK;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_LOOK, S_APPEND: begin
        if (out_free) state_d = S_IDLE;
      end
      S_AGE_RD: state_d = S_AGE_EV;
      S_AGE_EV: begin
        if (!age_done) state_d = S_AGE_RD;
        else if (out_free) state_d = S_IDLE;
      end
      S_KEY_RD: state_d = S_KEY_EV;
      S_KEY_EV: begin
        if (!key_hit && !key_last) state_d = S_KEY_RD;
        else if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d     = op_q;
    e_time_d = e_time_q;
    e_key_d  = e_key_q;
    stream_d = stream_q;
    e_ref_d  = e_ref_q;
    pos_d    = pos_q;
    now_d    = now_q;
    limit_d  = limit_q;
    inv_d    = inv_q;
    wslot_d  = wslot_q;
    count_d  = count_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    idx_d    = idx_q;
    mem_req  = '0;
    load_out = 1'b0;
    res      = '0;
    res.held = count_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = op_e'(s_axis_tuser);
          e_time_d = s_axis_tdata[31:0];
          e_key_d  = s_axis_tdata[32];
          stream_d = s_axis_tdata[40:33];
          e_ref_d  = s_axis_tdata[72:41];
          pos_d    = s_axis_tdata[82:73];
          now_d    = s_axis_tdata[114:83];
          limit_d  = s_axis_tdata[146:115];
          inv_d    = s_axis_tdata[147];
        end
      end
      S_DECODE: begin
        if (out_free) begin
          unique case (op_q)
            OP_APPEND: begin
              mem_req.rd_en = 1'b1;
              mem_req.addr  = wslot_q;
            end
            OP_CLEAR: begin
              count_d    = '0;
              wslot_d    = '0;
              load_out   = 1'b1;
              res.status = ST_OK;
              res.held   = '0;
            end
            OP_READ: begin
              if (empty) begin
                load_out   = 1'b1;
                res.status = ST_EMPTY;
              end else if (rng_bad) begin
                load_out   = 1'b1;
                res.status = ST_RANGE;
              end else begin
                mem_req.rd_en = 1'b1;
                mem_req.addr  = slot_of(wslot_q, count_q, pos_q);
                idx_d         = pos_ext;
              end
            end
            OP_AGE: begin
              if (empty) begin
                load_out   = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                lo_d = '0;
                hi_d = count_q;
              end
            end
            OP_KEY: begin
              if (empty) begin
                load_out   = 1'b1;
                res.status = ST_EMPTY;
              end else if (rng_bad) begin
                load_out   = 1'b1;
                res.status = ST_NOTFOUND;
              end else begin
                idx_d = pos_ext;
              end
            end
            OP_NEXT: begin
              if (empty) begin
                load_out   = 1'b1;
                res.status = ST_EMPTY;
              end else if (!nxt_ok) begin
                load_out   = 1'b1;
                res.status = ST_NOTFOUND;
                res.pos    = pos_q;
              end else begin
                mem_req.rd_en = 1'b1;
                mem_req.addr  = slot_of(wslot_q, count_q, nxt_pos[AW-1:0]);
                idx_d         = nxt_pos;
              end
            end
            default: begin
              load_out   = 1'b1;
              res.status = ST_OK;
            end
          endcase
        end
      end
      S_LOOK: begin
        if (out_free) begin
          load_out   = 1'b1;
          res.status = ST_OK;
          res.pos    = idx_q[AW-1:0];
          res.entry  = rd_data;
        end
      end
      S_APPEND: begin
        if (out_free) begin
          mem_req.wr_en        = 1'b1;
          mem_req.addr         = wslot_q;
          mem_req.wdata.time_v = e_time_q;
          mem_req.wdata.is_key = e_key_q;
          mem_req.wdata.stream = stream_q;
          mem_req.wdata.ref_v  = e_ref_q;
          wslot_d = (wslot_q == slot_t'(DEPTH - 1)) ? '0 : wslot_q + slot_t'(1);
          count_d = full ? count_q : count_q + cnt_t'(1);
          load_out     = 1'b1;
          res.status   = ST_OK;
          res.ev_valid = full;
          res.ev_ref   = full ? rd_data.ref_v : '0;
          res.held     = count_d;
        end
      end
      S_AGE_RD: begin
        idx_d         = mid_c;
        mem_req.rd_en = 1'b1;
        mem_req.addr  = slot_of(wslot_q, count_q, mid_c[AW-1:0]);
      end
      S_AGE_EV: begin
        if (age_done) begin
          if (out_free) begin
            load_out   = 1'b1;
            res.status = ST_OK;
            res.pos    = idx_q[AW-1:0];
            res.entry  = rd_data;
          end
        end else if (old_ok) begin
          lo_d = idx_q;
        end else begin
          hi_d = idx_q;
        end
      end
      S_KEY_RD: begin
        mem_req.rd_en = 1'b1;
        mem_req.addr  = slot_of(wslot_q, count_q, idx_q[AW-1:0]);
      end
      S_KEY_EV: begin
        if (key_hit) begin
          if (out_free) begin
            load_out   = 1'b1;
            res.status = ST_OK;
            res.pos    = idx_q[AW-1:0];
            res.entry  = rd_data;
          end
        end else if (key_last) begin
          if (out_free) begin
            load_out   = 1'b1;
            res.status = ST_NOTFOUND;
          end
        end else begin
          idx_d = idx_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (load_out) begin
      m_valid_d = 1'b1;
      m_data_d  = res;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wslot_q   <= '0;
      count_q   <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wslot_q   <= wslot_d;
      count_q   <= count_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    e_time_q <= e_time_d;
    e_key_q  <= e_key_d;
    stream_q <= stream_d;
    e_ref_q  <= e_ref_d;
    pos_q    <= pos_d;
    now_q    <= now_d;
    limit_q  <= limit_d;
    inv_q    <= inv_d;
    m_data_q <= m_data_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_data_q};

endmodule

@@ sv/rrts_checker.sv @@
// Port-level checks for the replay ring and the bind that attaches them.
`timescale 1ns / 1ps
`include "replay_ring_time_search_defines.svh"
module rrts_checker
  import rrts_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  localparam int unsigned HELD_LO = 118;

  status_e     status;
  logic        ev_valid;
  cnt_t        held;

  assign status   = status_e'(m_axis_tdata[1:0]);
  assign ev_valid = m_axis_tdata[85];
  assign held     = m_axis_tdata[HELD_LO +: CW];

  `RRTS_ASSERT_IMP(a_held_max, m_axis_tvalid, held <= cnt_t'(DEPTH), "held count above depth")
  `RRTS_ASSERT_IMP(a_evict_full, m_axis_tvalid && ev_valid, held == cnt_t'(DEPTH), "eviction while not full")
  `RRTS_ASSERT_IMP(a_empty_zero, m_axis_tvalid && status == ST_EMPTY, held == '0, "empty status with entries held")
  `RRTS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")

endmodule

bind replay_ring_time_search rrts_checker u_rrts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
